/* hdl/mrf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_pkg
// Shared constants and types of the drop-oldest message ring FIFO.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam int MRF_DEPTH         = 8;
    localparam int MRF_MAX_MSG_BYTES = 128;

    localparam int MRF_WORD_W  = 64;
    localparam int MRF_BYTES_W = 4;
    localparam int MRF_NODE_W  = 32;
    localparam int MRF_OLEN_W  = 8;
    localparam int MRF_HELD_W  = 4;

    // s_axis_tdata: word, word_bytes, source_node, dest_node, pad
    localparam int MRF_IN_TDATA_W  = 136;
    // m_axis_tdata: out_word, out_length, out_source, out_dest, held_count, pad
    localparam int MRF_OUT_TDATA_W = 144;

    localparam logic MRF_FUNC_WRITE = 1'b0;
    localparam logic MRF_FUNC_POP   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_POP
    } t_state;

endpackage
`default_nettype wire

/* hdl/mrf_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mrf_ram
// Simple dual-port RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mrf_ram #(
    parameter int WIDTH   = 64,
    parameter int ENTRIES = 128,
    parameter int AW      = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

/* hdl/message_ring_fifo_drop_oldest.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// message_ring_fifo_drop_oldest
// Message FIFO of DEPTH slots that drops the oldest message when full.
// ----------------------------------------------------------------------------
// A write item (tuser 0) takes one payload word; bytes are packed back to back
// into the slot and the item with tlast commits the message. The first word
// of a message drops the oldest stored one if all DEPTH slots are held. When
// the last word's bytes cross into the next payload entry, the tail is written
// in ST_FLUSH through the single write port and no item is accepted meanwhile.
// A pop item (tuser 1) is accepted in ST_IDLE and then streams ceil(length/8)
// words (at least one) at one word per cycle, paced by the registered read
// data of the payload RAM and by m_axis_tready. No new item is accepted until
// the pop has handed over its last word. A pop on an empty store returns one
// zeroed item with tuser (was_empty) set.
// ----------------------------------------------------------------------------
module message_ring_fifo_drop_oldest
    import mrf_pkg::*;
#(
    parameter int DEPTH         = MRF_DEPTH,
    parameter int MAX_MSG_BYTES = MRF_MAX_MSG_BYTES
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // [63:0] word, [67:64] word_bytes, [99:68] source_node,
    // [131:100] dest_node, [135:132] zero
    input  wire logic [MRF_IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  wire logic                       s_axis_tuser,
    input  wire logic                       s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [63:0] out_word, [71:64] out_length, [103:72] out_source,
    // [135:104] out_dest, [139:136] held_count, [143:140] zero
    output logic      [MRF_OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] was_empty
    output logic                            m_axis_tuser,
    output logic                            m_axis_tlast
);

    localparam int WPS = (MAX_MSG_BYTES + 7) / 8;
    localparam int SW  = $clog2(DEPTH);
    localparam int HW  = $clog2(DEPTH + 1);
    localparam int LW  = $clog2(MAX_MSG_BYTES + 1);
    localparam int PAW = (DEPTH * WPS > 1) ? $clog2(DEPTH * WPS) : 1;
    localparam int KW  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int CW  = ((KW + 3 > LW) ? KW + 3 : LW) + 1;
    localparam int MW  = LW + 2 * MRF_NODE_W;

    // input fields
    logic [MRF_WORD_W-1:0]  in_word;
    logic [MRF_BYTES_W-1:0] in_bytes;
    logic [MRF_NODE_W-1:0]  in_src;
    logic [MRF_NODE_W-1:0]  in_dst;

    assign in_word  = s_axis_tdata[63:0];
    assign in_bytes = s_axis_tdata[67:64];
    assign in_src   = s_axis_tdata[99:68];
    assign in_dst   = s_axis_tdata[131:100];

    t_state r_state, n_state;

    logic [SW-1:0]         r_wslot, n_wslot;
    logic [SW-1:0]         r_rslot, n_rslot;
    logic [HW-1:0]         r_held, n_held;
    logic [LW-1:0]         r_fill, n_fill;
    logic                  r_in_msg, n_in_msg;
    logic [MRF_WORD_W-1:0] r_acc, n_acc;
    logic [MRF_NODE_W-1:0] r_src, n_src;
    logic [MRF_NODE_W-1:0] r_dst, n_dst;
    logic [MRF_WORD_W-1:0] r_flush_word, n_flush_word;
    logic [PAW-1:0]        r_flush_addr, n_flush_addr;
    logic [PAW-1:0]        r_pop_base, n_pop_base;
    logic [KW-1:0]         r_k, n_k;
    logic                  r_pop_empty, n_pop_empty;
    logic                  r_m_valid, n_m_valid;

    logic [MRF_WORD_W-1:0] r_o_word;
    logic [MRF_OLEN_W-1:0] r_o_len;
    logic [MRF_NODE_W-1:0] r_o_src;
    logic [MRF_NODE_W-1:0] r_o_dst;
    logic                  r_o_last;
    logic                  r_o_empty;
    logic [MRF_HELD_W-1:0] r_o_held;

    // handshakes and control
    logic wr_acc, pop_acc, out_free, pop_emit;
    logic spill_last;

    // write path
    logic [LW-1:0]           fill_eff;
    logic [MRF_WORD_W-1:0]   acc_eff;
    logic [2:0]              pos;
    logic [MRF_BYTES_W-1:0]  nb_c, nbe;
    logic [LW-1:0]           room;
    logic [MRF_WORD_W-1:0]   word_m;
    logic [2*MRF_WORD_W-1:0] comb_w;
    logic [MRF_BYTES_W-1:0]  pos_sum;
    logic [PAW-1:0]          wr_addr;
    logic                    drop;

    // RAM ports
    logic                  pay_we, pay_re;
    logic [PAW-1:0]        pay_waddr, pay_raddr;
    logic [MRF_WORD_W-1:0] pay_wdata, pay_rdata;
    logic                  meta_we;
    logic [MW-1:0]         meta_wdata, meta_rdata;

    // pop path
    logic [LW-1:0]         m_len;
    logic [MRF_NODE_W-1:0] m_src, m_dst;
    logic [CW-1:0]         k_off;
    logic                  word_last;
    logic [MRF_WORD_W-1:0] out_word_m;

    assign out_free = !r_m_valid || m_axis_tready;
    assign wr_acc   = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MRF_FUNC_WRITE);
    assign pop_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser == MRF_FUNC_POP);

    assign m_len = meta_rdata[MW-1 -: LW];
    assign m_src = meta_rdata[2*MRF_NODE_W-1:MRF_NODE_W];
    assign m_dst = meta_rdata[MRF_NODE_W-1:0];

    // ---- write path: pack bytes at the current fill position
    always_comb begin
        fill_eff = r_in_msg ? r_fill : '0;
        acc_eff  = r_in_msg ? r_acc : '0;
        pos      = fill_eff[2:0];
        nb_c     = (in_bytes > 4'd8) ? 4'd8 : in_bytes;
        room     = LW'(MAX_MSG_BYTES) - fill_eff;
        nbe      = (room < LW'(nb_c)) ? room[MRF_BYTES_W-1:0] : nb_c;
        for (int b = 0; b < 8; b++) begin
            word_m[b*8 +: 8] = (MRF_BYTES_W'(b) < nbe) ? in_word[b*8 +: 8] : 8'h00;
        end
        comb_w     = {{MRF_WORD_W{1'b0}}, acc_eff}
                   | ({{MRF_WORD_W{1'b0}}, word_m} << {pos, 3'b000});
        pos_sum    = {1'b0, pos} + nbe;
        wr_addr    = PAW'(r_wslot) * PAW'(WPS) + PAW'(fill_eff >> 3);
        drop       = !r_in_msg && (r_held >= HW'(DEPTH));
        spill_last = s_axis_tlast && (pos_sum > 4'd8);
    end

    // ---- pop path: mask bytes past the length
    always_comb begin
        k_off = CW'({r_k, 3'b000});
        for (int b = 0; b < 8; b++) begin
            out_word_m[b*8 +: 8] = ((k_off + CW'(b)) < CW'(m_len)) ?
                                   pay_rdata[b*8 +: 8] : 8'h00;
        end
        word_last = (k_off + CW'(8)) >= CW'(m_len);
    end

    // ---- state machine: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (wr_acc && spill_last) begin
                    n_state = ST_FLUSH;
                end else if (pop_acc) begin
                    n_state = ST_POP;
                end
            end
            ST_FLUSH: begin
                n_state = ST_IDLE;
            end
            ST_POP: begin
                if (out_free && (r_pop_empty || word_last)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- state machine: outputs
    always_comb begin
        s_axis_tready = 1'b0;
        pop_emit      = 1'b0;
        pay_we        = 1'b0;
        pay_waddr     = wr_addr;
        pay_wdata     = comb_w[MRF_WORD_W-1:0];
        pay_re        = 1'b0;
        pay_raddr     = PAW'(r_rslot) * PAW'(WPS);
        meta_we       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                // a partial entry is written back even when the word adds no bytes
                pay_we        = wr_acc && ((nbe != '0) || (pos != '0));
                meta_we       = wr_acc && s_axis_tlast;
                pay_re        = pop_acc && (r_held != '0);
            end
            ST_FLUSH: begin
                pay_we    = 1'b1;
                pay_waddr = r_flush_addr;
                pay_wdata = r_flush_word;
            end
            ST_POP: begin
                pop_emit  = out_free;
                pay_re    = out_free && !r_pop_empty && !word_last;
                pay_raddr = r_pop_base + PAW'(r_k) + PAW'(1);
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign meta_wdata = {n_fill, (r_in_msg ? r_src : in_src), (r_in_msg ? r_dst : in_dst)};

    // ---- next values of the control and data registers
    always_comb begin
        n_wslot      = r_wslot;
        n_rslot      = r_rslot;
        n_held       = r_held;
        n_fill       = fill_eff + LW'(nbe);
        n_in_msg     = r_in_msg;
        n_acc        = r_acc;
        n_src        = r_src;
        n_dst        = r_dst;
        n_flush_word = comb_w[2*MRF_WORD_W-1:MRF_WORD_W];
        n_flush_addr = wr_addr + PAW'(1);
        n_pop_base   = r_pop_base;
        n_k          = r_k;
        n_pop_empty  = r_pop_empty;
        n_m_valid    = m_axis_tready ? 1'b0 : r_m_valid;

        if (wr_acc) begin
            n_acc = (pos_sum >= 4'd8) ? comb_w[2*MRF_WORD_W-1:MRF_WORD_W]
                                      : comb_w[MRF_WORD_W-1:0];
            if (!r_in_msg) begin
                n_src = in_src;
                n_dst = in_dst;
            end
            if (drop) begin
                n_rslot = (r_rslot == SW'(DEPTH - 1)) ? '0 : r_rslot + SW'(1);
            end
            if (s_axis_tlast) begin
                n_wslot  = (r_wslot == SW'(DEPTH - 1)) ? '0 : r_wslot + SW'(1);
                n_in_msg = 1'b0;
                if (!drop) begin
                    n_held = r_held + HW'(1);
                end
            end else begin
                n_in_msg = 1'b1;
                if (drop) begin
                    n_held = r_held - HW'(1);
                end
            end
        end else begin
            n_fill = r_fill;
        end

        if (pop_acc) begin
            n_k         = '0;
            n_pop_base  = PAW'(r_rslot) * PAW'(WPS);
            n_pop_empty = (r_held == '0);
            if (r_held != '0) begin
                n_rslot = (r_rslot == SW'(DEPTH - 1)) ? '0 : r_rslot + SW'(1);
                n_held  = r_held - HW'(1);
            end
        end

        if (pop_emit) begin
            n_m_valid = 1'b1;
            if (!r_pop_empty && !word_last) begin
                n_k = r_k + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wslot   <= '0;
            r_rslot   <= '0;
            r_held    <= '0;
            r_fill    <= '0;
            r_in_msg  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wslot   <= n_wslot;
            r_rslot   <= n_rslot;
            r_held    <= n_held;
            r_fill    <= n_fill;
            r_in_msg  <= n_in_msg;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_flush_word <= n_flush_word;
        r_flush_addr <= n_flush_addr;
        r_pop_base   <= n_pop_base;
        r_k          <= n_k;
        r_pop_empty  <= n_pop_empty;
        if (pop_emit) begin
            if (r_pop_empty) begin
                r_o_word  <= '0;
                r_o_len   <= '0;
                r_o_src   <= '0;
                r_o_dst   <= '0;
                r_o_last  <= 1'b1;
                r_o_empty <= 1'b1;
                r_o_held  <= '0;
            end else begin
                r_o_word  <= out_word_m;
                r_o_len   <= MRF_OLEN_W'(m_len);
                r_o_src   <= m_src;
                r_o_dst   <= m_dst;
                r_o_last  <= word_last;
                r_o_empty <= 1'b0;
                r_o_held  <= MRF_HELD_W'(r_held);
            end
        end
    end

    mrf_ram #(
        .WIDTH   (MRF_WORD_W),
        .ENTRIES (DEPTH * WPS),
        .AW      (PAW)
    ) u_payload (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (pay_wdata),
        .i_re    (pay_re),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    mrf_ram #(
        .WIDTH   (MW),
        .ENTRIES (DEPTH),
        .AW      (SW)
    ) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (r_wslot),
        .i_wdata (meta_wdata),
        .i_re    (pay_re && (r_state == ST_IDLE)),
        .i_raddr (r_rslot),
        .o_rdata (meta_rdata)
    );

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {4'b0000, r_o_held, r_o_dst, r_o_src, r_o_len, r_o_word};
    assign m_axis_tuser  = r_o_empty;
    assign m_axis_tlast  = r_o_last;

endmodule
`default_nettype wire
